// ----- hw/rtl/pps_pkg.sv -----
// Package for the pure-pursuit steering block: register indexes, angle limits,
// the CORDIC arctangent table and the result type of the CORDIC unit.
// No dependencies.
`default_nettype none

package pps_pkg;

  // Configuration register indexes
  localparam logic REG_LOOKAHEAD = 1'b0;
  localparam logic REG_SPEED     = 1'b1;

  localparam logic [14:0] LOOKAHEAD_RESET = 15'd512;  // 0.5 m in Q10
  localparam logic [14:0] SPEED_RESET     = 15'd205;  // 0.2 m/s in Q10

  localparam int unsigned ATAN_LEN  = 24;
  localparam int unsigned ANGLE_MAX = 12868;  // pi/2 in Q13
  localparam int unsigned CORD_W    = 45;     // holds vectors up to 2^43
  localparam int unsigned Z_W       = 33;     // Q30 angle accumulator

  typedef struct packed {
    logic        done;
    logic [13:0] angle;  // magnitude, Q13, 0 .. ANGLE_MAX
  } cordic_res_t;

  // atan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd843314857;
      5'd1:    v = 30'd497837830;
      5'd2:    v = 30'd263043837;
      5'd3:    v = 30'd133525159;
      5'd4:    v = 30'd67021687;
      5'd5:    v = 30'd33543516;
      5'd6:    v = 30'd16775851;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194283;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048576;
      5'd11:   v = 30'd524288;
      5'd12:   v = 30'd262144;
      5'd13:   v = 30'd131072;
      5'd14:   v = 30'd65536;
      5'd15:   v = 30'd32768;
      5'd16:   v = 30'd16384;
      5'd17:   v = 30'd8192;
      5'd18:   v = 30'd4096;
      5'd19:   v = 30'd2048;
      5'd20:   v = 30'd1024;
      5'd21:   v = 30'd512;
      5'd22:   v = 30'd256;
      5'd23:   v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pps_cordic.sv -----
// Iterative vectoring CORDIC: atan2(num, den) for non-negative operands.
// Normalizes, runs one micro-rotation per cycle, rounds to Q13. Uses pps_pkg.
`default_nettype none

module pps_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [31:0]          num_i,
  input  wire logic [31:0]          den_i,
  output pps_pkg::cordic_res_t      res_o
);

  localparam int unsigned STEPS_RUN =
    (CORDIC_STEPS > pps_pkg::ATAN_LEN) ? pps_pkg::ATAN_LEN : CORDIC_STEPS;
  localparam logic [4:0] LAST_STEP = 5'(STEPS_RUN - 1);

  localparam logic [1:0] CS_IDLE = 2'd0;
  localparam logic [1:0] CS_NORM = 2'd1;
  localparam logic [1:0] CS_ITER = 2'd2;
  localparam logic [1:0] CS_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic signed [pps_pkg::CORD_W-1:0] xv_q, xv_d, yv_q, yv_d;
  logic signed [pps_pkg::CORD_W-1:0] xs, ys;
  logic [pps_pkg::CORD_W-1:0] mag;
  logic signed [pps_pkg::Z_W-1:0] z_q, z_d, atan_ext, zr, zs;
  logic [4:0]  i_q, i_d;
  logic        done_q, done_d;
  logic [13:0] angle_q, angle_d;

  assign xs       = xv_q >>> i_q;
  assign ys       = yv_q >>> i_q;
  assign mag      = xv_q | yv_q;
  assign atan_ext = $signed({3'b000, pps_pkg::atan_q30(i_q)});
  assign zr       = z_q + $signed(33'd65536);
  assign zs       = zr >>> 17;

  always_comb begin
    state_d = state_q;
    xv_d    = xv_q;
    yv_d    = yv_q;
    z_d     = z_q;
    i_d     = i_q;
    done_d  = 1'b0;
    angle_d = angle_q;
    case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          xv_d = $signed({13'd0, den_i});
          yv_d = $signed({13'd0, num_i});
          z_d  = '0;
          i_d  = '0;
          // zero vector: skip straight to rounding of a zero angle
          state_d = ((num_i == '0) && (den_i == '0)) ? CS_FIN : CS_NORM;
        end
      end
      CS_NORM: begin
        // shift coarse, then fine, until the larger operand reaches 2^40
        if (mag[44:32] == '0) begin
          xv_d = xv_q <<< 8;
          yv_d = yv_q <<< 8;
        end else if (mag[44:40] == '0) begin
          xv_d = xv_q <<< 1;
          yv_d = yv_q <<< 1;
        end else begin
          state_d = CS_ITER;
        end
      end
      CS_ITER: begin
        if (yv_q > 0) begin
          xv_d = xv_q + ys;
          yv_d = yv_q - xs;
          z_d  = z_q + atan_ext;
        end else begin
          xv_d = xv_q - ys;
          yv_d = yv_q + xs;
          z_d  = z_q - atan_ext;
        end
        i_d = i_q + 5'd1;
        if (i_q == LAST_STEP) begin
          state_d = CS_FIN;
        end
      end
      CS_FIN: begin
        if (zs[pps_pkg::Z_W-1]) begin
          angle_d = '0;
        end else if (zs > $signed(33'(pps_pkg::ANGLE_MAX))) begin
          angle_d = 14'(pps_pkg::ANGLE_MAX);
        end else begin
          angle_d = zs[13:0];
        end
        done_d  = 1'b1;
        state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xv_q    <= xv_d;
    yv_q    <= yv_d;
    z_q     <= z_d;
    i_q     <= i_d;
    angle_q <= angle_d;
  end

  assign res_o.done  = done_q;
  assign res_o.angle = angle_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == CS_IDLE)
    else $error("cordic started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("cordic done longer than one cycle");
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> angle_q <= 14'(pps_pkg::ANGLE_MAX))
    else $error("cordic angle out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/pure_pursuit_steering.sv -----
// Pure-pursuit steering: picks the first path point at or beyond the lookahead
// radius and returns atan2(2y, x^2+y^2) in Q13 with the speed command.
// The input stalls from accept until the word is dropped or its output word is
// loaded, which waits while a stalled output word is still held. A steering word
// runs at most 12 normalize shifts, and the CORDIC steps are capped at 24.
// Reset: 0.5 m lookahead, 0.2 m/s, no target taken, output empty.
// Uses pps_pkg and pps_cordic.
`default_nettype none

module pure_pursuit_steering #(
  parameter int unsigned COORD_FRAC_BITS = 10,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [14:0]        cfg_wdata_i,
  // input words
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [15:0] point_x_i,
  input  wire logic signed [15:0] point_y_i,
  input  wire logic               last_point_i,
  // output words
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic               status_o,
  output      logic signed [14:0] steer_angle_o,
  output      logic [14:0]        speed_o
);

  // Sequencer: one shared squarer computes x^2, y^2 and L^2 in turn, then a
  // compare decides between steering (CORDIC), a no-point word, or nothing.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQX  = 3'd1;
  localparam logic [2:0] ST_SQY  = 3'd2;
  localparam logic [2:0] ST_SQL  = 3'd3;
  localparam logic [2:0] ST_DEC  = 3'd4;
  localparam logic [2:0] ST_CORD = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [14:0] look_q, speed_cfg_q;
  logic [15:0] ax_q, ay_q, ax_d, ay_d;
  logic        yneg_q, yneg_d, last_q, last_d;
  logic        taken_q, taken_d;
  logic [31:0] sq_q, sq_d, d2_q, d2_d;
  logic [15:0] mul_a;
  logic [31:0] prod;
  logic        hit;
  logic        in_acc;
  logic        cord_start;
  logic [31:0] cord_num;
  pps_pkg::cordic_res_t cres;
  logic        rs_status_q, rs_status_d;
  logic [14:0] rs_angle_q, rs_angle_d;
  logic [14:0] ang_ext;
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic        out_status_q;
  logic [14:0] out_angle_q, out_speed_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Shared squarer: operand is chosen by the sequencer state
  always_comb begin
    case (state_q)
      ST_SQX:  mul_a = ax_q;
      ST_SQY:  mul_a = ay_q;
      default: mul_a = {1'b0, look_q};
    endcase
  end
  assign prod = mul_a * mul_a;

  assign hit      = !taken_q && (d2_q >= sq_q);
  assign cord_num = 32'({ay_q, 1'b0}) << COORD_FRAC_BITS;
  assign ang_ext  = {1'b0, cres.angle};

  // Output register frees when its word is taken
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    yneg_d      = yneg_q;
    last_d      = last_q;
    taken_d     = taken_q;
    sq_d        = sq_q;
    d2_d        = d2_q;
    rs_status_d = rs_status_q;
    rs_angle_d  = rs_angle_q;
    cord_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // take magnitudes; -32768 becomes 32768 in 16 unsigned bits
          ax_d    = point_x_i[15] ? 16'(-point_x_i) : 16'(point_x_i);
          ay_d    = point_y_i[15] ? 16'(-point_y_i) : 16'(point_y_i);
          yneg_d  = point_y_i[15];
          last_d  = last_point_i;
          state_d = ST_SQX;
        end
      end
      ST_SQX: begin
        sq_d    = prod;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        d2_d    = sq_q;
        sq_d    = prod;
        state_d = ST_SQL;
      end
      ST_SQL: begin
        d2_d    = d2_q + sq_q;
        sq_d    = prod;
        state_d = ST_DEC;
      end
      ST_DEC: begin
        // drop points after the target; clear the pass flag on the last point
        taken_d = last_q ? 1'b0 : (taken_q || hit);
        if (hit) begin
          cord_start = 1'b1;
          state_d    = ST_CORD;
        end else if (last_q && !taken_q) begin
          rs_status_d = 1'b1;
          rs_angle_d  = '0;
          state_d     = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CORD: begin
        if (cres.done) begin
          rs_status_d = 1'b0;
          rs_angle_d  = yneg_q ? 15'(15'd0 - ang_ext) : ang_ext;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  pps_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cord_start),
    .num_i  (cord_num),
    .den_i  (d2_q),
    .res_o  (cres)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_q      <= pps_pkg::LOOKAHEAD_RESET;
      speed_cfg_q <= pps_pkg::SPEED_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pps_pkg::REG_LOOKAHEAD: look_q      <= cfg_wdata_i;
        pps_pkg::REG_SPEED:     speed_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      taken_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk_i) begin
    ax_q        <= ax_d;
    ay_q        <= ay_d;
    yneg_q      <= yneg_d;
    last_q      <= last_d;
    sq_q        <= sq_d;
    d2_q        <= d2_d;
    rs_status_q <= rs_status_d;
    rs_angle_q  <= rs_angle_d;
    if (out_load) begin
      out_status_q <= rs_status_q;
      out_angle_q  <= rs_angle_q;
      out_speed_q  <= rs_status_q ? 15'd0 : speed_cfg_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign steer_angle_o = $signed(out_angle_q);
  assign speed_o       = out_speed_q;

  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_SQX)
    else $error("accepted word did not start the sequence");
  a_done_in_cord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cres.done |-> state_q == ST_CORD)
    else $error("cordic result arrived outside wait state");
  a_nopoint_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (steer_angle_o == 15'sd0 && speed_o == 15'd0))
    else $error("no-point word carries nonzero payload");
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (steer_angle_o <= 15'sd12868 && steer_angle_o >= -15'sd12868))
    else $error("steering angle out of range");

endmodule

`default_nettype wire
